FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the atom update block checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VVA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("atom update assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VVA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("atom update assertion failed");

`endif

FILE: design/vva_pkg.sv
// ---------------------------------------------------------------------------
// vva_pkg
// Types, constants and helpers shared by the atom update block.
// ---------------------------------------------------------------------------
package vva_pkg;

  localparam int SPECIES_COUNT_DEF = 4;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int REG_W             = 31;
  localparam int IDX_W             = 3;
  localparam int CFG_DATA_W        = 32;
  localparam int MUL_W             = 33;
  localparam int PROD_W            = 2 * MUL_W;
  localparam int WIDE_W            = 96;
  localparam int SUM_W             = 63;

  localparam logic [IDX_W-1:0] REG_TIME_STEP    = 3'd0;
  localparam logic [IDX_W-1:0] REG_FORCE_SCALE  = 3'd1;
  localparam logic [IDX_W-1:0] REG_ENERGY_SCALE = 3'd2;
  localparam logic [IDX_W-1:0] REG_MASS_BASE    = 3'd3;

  localparam logic [REG_W-1:0] REG_RESET = 31'd65536;
  localparam logic [REG_W-1:0] REG_MAX   = 31'h7FFF_FFFF;
  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

  localparam logic [1:0] CMD_KICK_DRIFT = 2'd0;
  localparam logic [1:0] CMD_KICK       = 2'd1;
  localparam logic [1:0] CMD_ENERGY     = 2'd2;

  localparam logic signed [PROD_W-1:0] S32_MAX = {{34{1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [PROD_W-1:0] S32_MIN = {{34{1'b1}}, 32'h8000_0000};

  typedef struct packed {
    logic [1:0]         cmd;
    logic [1:0]         species;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               last_atom;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic [SUM_W-1:0]   kinetic_total;
    logic               energy_valid;
  } out_item_t;

  // Clamp a wide signed value into the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: design/vva_ifs.sv
// ---------------------------------------------------------------------------
// vva_ifs
// Valid/ready channel interfaces for items, results and register writes.
// ---------------------------------------------------------------------------
interface vva_in_if;
  logic              valid;
  logic              ready;
  vva_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface vva_out_if;
  logic               valid;
  logic               ready;
  vva_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface vva_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vva_pkg::IDX_W-1:0]       index;
  logic [vva_pkg::CFG_DATA_W-1:0]  wdata;
  modport source(output valid, output index, output wdata, input ready);
  modport sink(input valid, input index, input wdata, output ready);
endinterface

FILE: design/vva_div.sv
// ---------------------------------------------------------------------------
// vva_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module vva_div #(
  parameter int NUM_W = 47,
  parameter int DEN_W = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Shift in the next dividend bit and try a subtract.
  assign trial = {rem_r, quot_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  // Control: busy flag, bit counter and done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (busy_r) begin
      quot_r <= {quot_r[NUM_W-2:0], ge};
      rem_r  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = quot_r;
endmodule

FILE: design/vva_mul.sv
// ---------------------------------------------------------------------------
// vva_mul
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module vva_mul (
  input  logic                               clk,
  input  logic signed [vva_pkg::MUL_W-1:0]   a,
  input  logic signed [vva_pkg::MUL_W-1:0]   b,
  output logic signed [vva_pkg::PROD_W-1:0]  p
);
  import vva_pkg::*;

  logic signed [PROD_W-1:0] p_r;

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk) begin
    p_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign p = p_r;
endmodule

FILE: design/velocity_verlet_atom_update.sv
// Per command: cmd 0 kicks and drifts, cmd 1 kicks, cmd 2 adds kinetic energy and scales
// the total on the last atom, cmd 3 passes the item through.
// One item is in work at a time; the next is taken in the cycle after its result is loaded,
// and a result waiting on the output holds the block. The serial divider for scale over
// mass and the shared multiplier set the rate. Reset (synchronous, active low) clears
// the energy sum and sets every configuration register to 1.0 at Q16.16.
// ---------------------------------------------------------------------------
// velocity_verlet_atom_update
// Velocity Verlet kick, drift and kinetic energy sum for one atom per item.
// ---------------------------------------------------------------------------
module velocity_verlet_atom_update #(
  parameter int SPECIES_COUNT = vva_pkg::SPECIES_COUNT_DEF,
  parameter int FRAC_BITS     = vva_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  vva_in_if.sink    in_ch,
  vva_out_if.source out_ch,
  vva_cfg_if.sink   cfg_ch
);
  import vva_pkg::*;

  localparam int DIV_W = REG_W + FRAC_BITS;
  localparam int SP_W  = (SPECIES_COUNT > 1) ? $clog2(SPECIES_COUNT) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_KT   = 4'd2;
  localparam logic [3:0] S_KV   = 4'd3;
  localparam logic [3:0] S_KX   = 4'd4;
  localparam logic [3:0] S_ESQ  = 4'd5;
  localparam logic [3:0] S_EM0  = 4'd6;
  localparam logic [3:0] S_EM1  = 4'd7;
  localparam logic [3:0] S_EACC = 4'd8;
  localparam logic [3:0] S_ET0  = 4'd9;
  localparam logic [3:0] S_ET1  = 4'd10;
  localparam logic [3:0] S_ETOT = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  // Configuration registers.
  logic [REG_W-1:0] dt_r;
  logic [REG_W-1:0] fscale_r;
  logic [REG_W-1:0] escale_r;
  logic [REG_W-1:0] mass_r [SPECIES_COUNT];
  logic [REG_W-1:0] cfg_val;

  // Sequencer and item registers.
  logic [3:0]         state_r, state_nxt;
  logic [1:0]         ax_r, ax_nxt;
  logic               ph_r, ph_nxt;
  logic [1:0]         cmd_r;
  logic               last_r;
  logic [REG_W-1:0]   imass_r;
  logic [REG_W-1:0]   acc_r;
  logic signed [31:0] t_r;
  logic signed [31:0] pos_r [3];
  logic signed [31:0] vel_r [3];
  logic signed [31:0] frc_r [3];
  logic [63:0]        v2_r;
  logic [WIDE_W-1:0]  wide_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   total_r;
  logic               evalid_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic                     in_acc;
  logic                     div_start;
  logic                     div_done;
  logic [DIV_W-1:0]         div_quot;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [SP_W-1:0]          sp_idx;
  logic signed [PROD_W-1:0] vsum, xsum;
  logic [WIDE_W-1:0]        wide_hi;
  logic [WIDE_W-1:0]        term_w;
  logic [SUM_W-1:0]         term;
  logic [SUM_W:0]           sum_add;
  logic [WIDE_W-1:0]        tot_w;
  logic                     out_load;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && (state_r == S_IDLE);
  assign div_start    = in_acc && (in_ch.data.cmd == CMD_KICK_DRIFT ||
                                   in_ch.data.cmd == CMD_KICK);

  // A register written with zero holds one instead.
  assign cfg_val = (cfg_ch.wdata[REG_W-1:0] == '0) ? REG_W'(1) : cfg_ch.wdata[REG_W-1:0];

  // Register file writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r     <= REG_RESET;
      fscale_r <= REG_RESET;
      escale_r <= REG_RESET;
      for (int i = 0; i < SPECIES_COUNT; i++) begin
        mass_r[i] <= REG_RESET;
      end
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_TIME_STEP) begin
        dt_r <= cfg_val;
      end
      if (cfg_ch.index == REG_FORCE_SCALE) begin
        fscale_r <= cfg_val;
      end
      if (cfg_ch.index == REG_ENERGY_SCALE) begin
        escale_r <= cfg_val;
      end
      for (int i = 0; i < SPECIES_COUNT; i++) begin
        if (cfg_ch.index == REG_MASS_BASE + IDX_W'(i)) begin
          mass_r[i] <= cfg_val;
        end
      end
    end
  end

  // Species beyond the count use the last species.
  assign sp_idx = (int'(in_ch.data.species) >= SPECIES_COUNT) ?
                  SP_W'(SPECIES_COUNT - 1) : SP_W'(in_ch.data.species);

  // Serial divider for scale over mass.
  vva_div #(.NUM_W(DIV_W), .DEN_W(REG_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({fscale_r, {FRAC_BITS{1'b0}}}),
    .den   (mass_r[sp_idx]),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_KT: begin
        mul_a = {frc_r[ax_r][31], frc_r[ax_r]};
        mul_b = {2'b00, acc_r};
      end
      S_KV: begin
        mul_a = {t_r[31], t_r};
        mul_b = {2'b00, dt_r};
      end
      S_KX: begin
        mul_a = {vel_r[ax_r][31], vel_r[ax_r]};
        mul_b = {2'b00, dt_r};
      end
      S_ESQ: begin
        mul_a = {vel_r[ax_r][31], vel_r[ax_r]};
        mul_b = {vel_r[ax_r][31], vel_r[ax_r]};
      end
      S_EM0: begin
        mul_a = {1'b0, v2_r[31:0]};
        mul_b = {2'b00, imass_r};
      end
      S_EM1: begin
        mul_a = {1'b0, v2_r[63:32]};
        mul_b = {2'b00, imass_r};
      end
      S_ET0: begin
        mul_a = {1'b0, sum_r[31:0]};
        mul_b = {2'b00, escale_r};
      end
      S_ET1: begin
        mul_a = {2'b00, sum_r[62:32]};
        mul_b = {2'b00, escale_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  vva_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Result arithmetic on the registered product.
  assign vsum    = PROD_W'(vel_r[ax_r]) + (prod >>> (FRAC_BITS + 1));
  assign xsum    = PROD_W'(pos_r[ax_r]) + (prod >>> FRAC_BITS);
  assign wide_hi = wide_r + {prod[63:0], 32'h0};
  assign term_w  = wide_r >> (2 * FRAC_BITS);
  assign term    = (|term_w[WIDE_W-1:SUM_W]) ? SUM_MAX : term_w[SUM_W-1:0];
  assign sum_add = {1'b0, sum_r} + {1'b0, term};
  assign tot_w   = wide_r >> (FRAC_BITS + 1);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    ph_nxt    = ph_r;
    unique case (state_r) inside
      S_IDLE: begin
        ax_nxt = 2'd0;
        ph_nxt = 1'b0;
        if (in_acc) begin
          if (div_start) begin
            state_nxt = S_DIV;
          end else if (in_ch.data.cmd == CMD_ENERGY) begin
            state_nxt = S_ESQ;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_KT;
        end
      end
      S_KT, S_KV, S_KX, S_ESQ, S_EM0, S_EM1, S_ET0, S_ET1: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          unique case (state_r) inside
            S_KT:  state_nxt = S_KV;
            S_KV, S_KX: begin
              if (state_r == S_KV && cmd_r == CMD_KICK_DRIFT) begin
                state_nxt = S_KX;
              end else if (ax_r == 2'd2) begin
                state_nxt = S_OUT;
              end else begin
                ax_nxt    = ax_r + 2'd1;
                state_nxt = S_KT;
              end
            end
            S_ESQ: begin
              if (ax_r == 2'd2) begin
                state_nxt = S_EM0;
              end else begin
                ax_nxt = ax_r + 2'd1;
              end
            end
            S_EM0: state_nxt = S_EM1;
            S_EM1: state_nxt = S_EACC;
            S_ET0: state_nxt = S_ET1;
            default: state_nxt = S_ETOT;
          endcase
        end
      end
      S_EACC: state_nxt = last_r ? S_ET0 : S_OUT;
      S_ETOT: state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= 2'd0;
      ph_r        <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ax_r    <= ax_nxt;
      ph_r    <= ph_nxt;
      if (state_r == S_EACC) begin
        sum_r <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
      end else if (state_r == S_ETOT) begin
        sum_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_ch.data.cmd;
      last_r   <= in_ch.data.last_atom;
      imass_r  <= mass_r[sp_idx];
      pos_r[0] <= in_ch.data.pos_x;
      pos_r[1] <= in_ch.data.pos_y;
      pos_r[2] <= in_ch.data.pos_z;
      vel_r[0] <= in_ch.data.vel_x;
      vel_r[1] <= in_ch.data.vel_y;
      vel_r[2] <= in_ch.data.vel_z;
      frc_r[0] <= in_ch.data.force_x;
      frc_r[1] <= in_ch.data.force_y;
      frc_r[2] <= in_ch.data.force_z;
      v2_r     <= '0;
      total_r  <= '0;
      evalid_r <= 1'b0;
    end
    if (state_r == S_DIV && div_done) begin
      acc_r <= (|div_quot[DIV_W-1:REG_W]) ? REG_MAX : div_quot[REG_W-1:0];
    end
    if (ph_r) begin
      case (state_r)
        S_KT:  t_r <= sat32(prod >>> FRAC_BITS);
        S_KV:  vel_r[ax_r] <= sat32(vsum);
        S_KX:  pos_r[ax_r] <= sat32(xsum);
        S_ESQ: v2_r <= v2_r + prod[63:0];
        S_EM0: wide_r <= {32'h0, prod[63:0]};
        S_EM1: wide_r <= wide_hi;
        S_ET0: wide_r <= {32'h0, prod[63:0]};
        S_ET1: wide_r <= wide_hi;
        default: begin
        end
      endcase
    end
    if (state_r == S_ETOT) begin
      total_r  <= (|tot_w[WIDE_W-1:SUM_W]) ? SUM_MAX : tot_w[SUM_W-1:0];
      evalid_r <= 1'b1;
    end
    if (out_load) begin
      out_data_r.new_pos_x     <= pos_r[0];
      out_data_r.new_pos_y     <= pos_r[1];
      out_data_r.new_pos_z     <= pos_r[2];
      out_data_r.new_vel_x     <= vel_r[0];
      out_data_r.new_vel_y     <= vel_r[1];
      out_data_r.new_vel_z     <= vel_r[2];
      out_data_r.kinetic_total <= total_r;
      out_data_r.energy_valid  <= evalid_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
endmodule

FILE: design/vva_checker.sv
// ---------------------------------------------------------------------------
// vva_checker
// Port-level assertions for the atom update block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vva_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input vva_pkg::out_item_t  out_data,
  input logic                cfg_ready
);
  import vva_pkg::*;

  // A stalled result holds its value.
  `VVA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  // The block works on one item at a time.
  `VVA_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_valid && in_ready, !in_ready)
  // Energy total reads zero when no finished sum is reported.
  `VVA_ASSERT_IMPL(a_energy_zero, clk, rst_n, out_valid && !out_data.energy_valid, out_data.kinetic_total == '0)
  // Register writes are never held off.
  `VVA_ASSERT_IMPL(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)
endmodule

bind velocity_verlet_atom_update vva_checker u_vva_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data),
  .cfg_ready (cfg_ch.ready)
);
